### src/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Operation codes, result field widths and the per-cycle cell control word.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam int ENTRY_W = 5;

  typedef struct packed {
    logic ins;
    logic rem;
  } spq_ctrl_t;

endpackage

### src/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one key of the descending row. On insert it takes its left neighbor's
// key, the new key, or keeps its own; on removal it takes its right neighbor's.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int KEY_WIDTH = 16
) (
  input  logic                  clk,
  input  spq_pkg::spq_ctrl_t    ctrl,
  input  logic                  occupied,
  input  logic [KEY_WIDTH-1:0]  key_in,
  input  logic [KEY_WIDTH-1:0]  left_key,
  input  logic                  left_shift,
  input  logic [KEY_WIDTH-1:0]  right_key,
  output logic [KEY_WIDTH-1:0]  key,
  output logic                  shift
);
  import spq_pkg::*;

  assign shift = !occupied || (key <= key_in);

  always_ff @(posedge clk) begin
    if (ctrl.rem) begin
      key <= right_key;
    end else if (ctrl.ins) begin
      if (left_shift) begin
        key <= left_key;
      end else if (shift) begin
        key <= key_in;
      end
    end
  end

endmodule

### src/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue, top level
// The result strobe done rises in the cycle after start is taken.
// Throughput: one item per cycle; busy stays low, every cell updates in parallel.
// The row of cells keeps keys descending, so the largest key sits in cell 0.
// Reset clears the entry count, the result strobe and success; cell keys stay unset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind,
  input  logic [KEY_WIDTH-1:0]         key_in,
  output logic                         done,
  output logic                         success,
  output logic [KEY_WIDTH-1:0]         top_key,
  output logic                         is_empty,
  output logic [spq_pkg::ENTRY_W-1:0]  entry_count
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic                 full;
  logic                 empty;
  logic                 accept;
  logic                 do_ins;
  logic                 do_rem;
  spq_ctrl_t            ctrl;
  logic [KEY_WIDTH-1:0] keys [DEPTH];
  logic                 shifts [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign do_ins = accept && (kind == OP_INSERT) && !full;
  assign do_rem = accept && (kind == OP_REMOVE) && !empty;
  assign ctrl   = '{ins: do_ins, rem: do_rem};

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_rem) begin
      count_next = count - CW'(1);
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] left_key;
      logic                 left_shift;
      logic [KEY_WIDTH-1:0] right_key;

      if (i == 0) begin : g_first
        assign left_key   = key_in;
        assign left_shift = 1'b0;
      end else begin : g_mid
        assign left_key   = keys[i-1];
        assign left_shift = shifts[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign right_key = keys[i];
      end else begin : g_inner
        assign right_key = keys[i+1];
      end

      spq_cell #(
        .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (CW'(i) < count),
        .key_in     (key_in),
        .left_key   (left_key),
        .left_shift (left_shift),
        .right_key  (right_key),
        .key        (keys[i]),
        .shift      (shifts[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      done    <= 1'b0;
      success <= 1'b0;
    end else begin
      count   <= count_next;
      done    <= accept;
      success <= do_ins || do_rem;
    end
  end

  assign top_key     = empty ? '0 : keys[0];
  assign is_empty    = empty;
  assign entry_count = ENTRY_W'(count);

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start))
    else $error("result strobe without a taken item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(2)) |-> (keys[0] >= keys[1]))
    else $error("head cells out of order");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (done && !success && !$past(kind)) |-> (count == CW'(DEPTH)))
    else $error("insert rejected while not full");

endmodule

### tb/sorted_priority_queue_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and remove items through the command port, predicts every
// result with a private sorted-key model and checks each strobed result field
// by field. Directed corner items come first, then random bursts that swing
// the store between empty and full under several sender idle rates.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_test;

  import spq_pkg::*;

  localparam int QDEPTH = 16;
  localparam int KEY_W = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 285;

  typedef struct packed {
    logic               success;
    logic [KEY_W-1:0]   top_key;
    logic               is_empty;
    logic [ENTRY_W-1:0] entry_count;
  } queue_status_t;

  class queue_status_board;
    logic [KEY_W-1:0] keys_asc[QDEPTH];
    int unsigned      key_count;
    queue_status_t    expected_status[$];
    int unsigned      mismatches;

    function new();
      key_count = 0;
      mismatches = 0;
    endfunction

    function void note_item(logic op, logic [KEY_W-1:0] key);
      queue_status_t st;
      int unsigned pos;
      st.success = 1'b0;
      if (op == OP_INSERT) begin
        if (key_count < QDEPTH) begin
          pos = key_count;
          while (pos > 0 && keys_asc[pos-1] > key) begin
            keys_asc[pos] = keys_asc[pos-1];
            pos--;
          end
          keys_asc[pos] = key;
          key_count++;
          st.success = 1'b1;
        end
      end else begin
        if (key_count > 0) begin
          key_count--;
          st.success = 1'b1;
        end
      end
      st.top_key = (key_count > 0) ? keys_asc[key_count-1] : '0;
      st.is_empty = (key_count == 0);
      st.entry_count = key_count[ENTRY_W-1:0];
      expected_status.push_back(st);
    endfunction

    function void check_result(queue_status_t got);
      queue_status_t exp_st;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result success=%0b top=%h empty=%0b count=%0d",
                   $realtime, got.success, got.top_key, got.is_empty, got.entry_count);
        return;
      end
      exp_st = expected_status.pop_front();
      if (got.success !== exp_st.success || got.top_key !== exp_st.top_key ||
          got.is_empty !== exp_st.is_empty || got.entry_count !== exp_st.entry_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch success %0b/%0b top %h/%h empty %0b/%0b count %0d/%0d",
                   $realtime, exp_st.success, got.success, exp_st.top_key, got.top_key,
                   exp_st.is_empty, got.is_empty, exp_st.entry_count, got.entry_count);
      end
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               kind = OP_INSERT;
  logic [KEY_W-1:0]   key_in = '0;
  logic               busy;
  logic               done;
  logic               success;
  logic [KEY_W-1:0]   top_key;
  logic               is_empty;
  logic [ENTRY_W-1:0] entry_count;

  queue_status_board board = new();
  int unsigned       idle_pct = 0;
  int unsigned       quiet_cycles = 0;

  sorted_priority_queue_top #(
    .DEPTH(QDEPTH),
    .KEY_WIDTH(KEY_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .key_in(key_in),
    .done(done),
    .success(success),
    .top_key(top_key),
    .is_empty(is_empty),
    .entry_count(entry_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        board.check_result('{success, top_key, is_empty, entry_count});
      if (start && !busy)
        board.note_item(kind, key_in);
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct && gap < 200)
      gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= op;
    key_in <= key;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return KEY_W'($urandom_range(0, 7));
      4: return KEY_W'(16'hFFF8 + $urandom_range(0, 7));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  task automatic run_bursts(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst_len;
    int unsigned ins_pct;
    sent = 0;
    while (sent < n_items) begin
      burst_len = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0: ins_pct = 85;
        1: ins_pct = 50;
        default: ins_pct = 15;
      endcase
      repeat (burst_len) begin
        if ($urandom_range(0, 99) < ins_pct)
          send_item(OP_INSERT, pick_key());
        else
          send_item(OP_REMOVE, KEY_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned phase_idle[4];
    int unsigned drain_wait;
    phase_idle = '{0, 57, 0, 15};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_item(OP_REMOVE, '0);
    send_item(OP_INSERT, '0);
    send_item(OP_REMOVE, '1);
    send_item(OP_REMOVE, 16'h1234);
    send_item(OP_INSERT, '1);
    send_item(OP_INSERT, '1);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, 16'h0001);
    send_item(OP_REMOVE, '1);
    send_item(OP_INSERT, 16'h8000);
    send_item(OP_INSERT, 16'h7FFF);
    send_item(OP_INSERT, 16'hAAAA);
    send_item(OP_INSERT, 16'h5555);
    send_item(OP_INSERT, 16'h8000);
    send_item(OP_REMOVE, '0);
    send_item(OP_REMOVE, 16'hAAAA);
    send_item(OP_REMOVE, 16'h5555);
    send_item(OP_REMOVE, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_REMOVE, '0);

    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      run_bursts(ITEMS_PER_PHASE);
    end
    start <= 1'b0;

    drain_wait = 0;
    while (board.pending() != 0 && drain_wait < 100) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (4) @(posedge clk);

    if (board.mismatches == 0 && board.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
